/* rtl/first_fit_heap_allocator_core_defines.svh */
// Assertion macros for the first-fit heap allocator checker
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define FFHA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define FFHA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ffha_pkg.sv */
// Package: shared constants and codes of the first-fit heap allocator
`timescale 1ns / 1ps
package ffha_pkg;
    localparam int HEAP_BYTES_DEF   = 4096;
    localparam int ALIGN_BYTES_DEF  = 8;
    localparam int HEADER_BYTES_DEF = 32;

    localparam int ADDR_W  = 12;
    localparam int BYTES_W = 13;
    localparam int ALLOC_W = 14;
    localparam int STAT_W  = 2;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_ALLOC = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FREED = 2'd2;
    localparam logic [STAT_W-1:0] ST_ZERO  = 2'd3;
endpackage

/* rtl/first_fit_heap_allocator_core.sv */
// First-fit heap allocator with coalescing: one item at a time over a header RAM.
// The heap is kept as an address-ordered chain of block headers in one RAM row per
// aligned slot. After reset a clearing pass writes every row, during which no request is
// taken. Allocate walks the chain in first-fit order, then writes the free remainder,
// relinks the old successor if any and writes the granted header; a zero-size request
// and a walk that finds no fit go straight to the result. Free merges each free successor,
// then each free predecessor, writes the merged header and relinks its successor; an
// address that names no header goes straight to the result. The walk reads one header per
// cycle through the single RAM read port. A result waits in an output register and is held
// until taken; the next request is not taken before its result is in that register.
`timescale 1ns / 1ps
module first_fit_heap_allocator_core #(
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [12:0] request_bytes, [24:13] block_address, [31:25] zero
    input  logic [ffha_pkg::S_DATA_W-1:0] i_s_tdata,
    // [0] operation
    input  logic [0:0]                    i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [11:0] payload_address, [15:12] zero
    output logic [ffha_pkg::M_DATA_W-1:0] o_m_tdata,
    // [1:0] status
    output logic [ffha_pkg::STAT_W-1:0]   o_m_tuser
);
    import ffha_pkg::*;

    localparam int ALOG   = $clog2(ALIGN_BYTES);
    localparam int HEAP_A = ((HEAP_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int HDR    = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int DEPTH  = HEAP_A / ALIGN_BYTES;
    localparam int IW     = $clog2(DEPTH);
    localparam int LW     = IW + 1;
    localparam int SZW    = $clog2(HEAP_A + 1);
    localparam int CW     = ((SZW > ALLOC_W) ? SZW : ALLOC_W) + 1;
    localparam logic [LW-1:0]  NIL     = '1;
    localparam logic [IW-1:0]  LAST    = IW'(DEPTH - 1);
    localparam logic [SZW-1:0] HDR_SZ  = SZW'(HDR);
    localparam logic [SZW-1:0] INIT_SZ = SZW'(HEAP_A - HDR);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_A_CHK = 4'd2;
    localparam logic [3:0] S_A_FIX = 4'd3;
    localparam logic [3:0] S_A_WRB = 4'd4;
    localparam logic [3:0] S_F_CHK = 4'd5;
    localparam logic [3:0] S_F_FWD = 4'd6;
    localparam logic [3:0] S_F_BST = 4'd7;
    localparam logic [3:0] S_F_BWD = 4'd8;
    localparam logic [3:0] S_F_FIN = 4'd9;
    localparam logic [3:0] S_F_FIX = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    typedef struct packed {
        logic           valid;
        logic           free;
        logic [SZW-1:0] size;
        logic [LW-1:0]  nxt;
        logic [LW-1:0]  prv;
    } t_row;

    logic [3:0]          r_state, n_state;
    logic [IW-1:0]       r_b, n_b;
    logic [IW-1:0]       r_s, n_s;
    t_row                r_cur, n_cur;
    t_row                r_succ, n_succ;
    logic [ALLOC_W-1:0]  r_a, n_a;
    logic [CW-1:0]       r_need, n_need;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    logic [STAT_W-1:0]   r_res_st, n_res_st;
    logic                r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]   r_out_addr, n_out_addr;
    logic [STAT_W-1:0]   r_out_st, n_out_st;

    logic                we;
    logic [IW-1:0]       waddr, raddr;
    t_row                wrow, q;
    logic [$bits(t_row)-1:0] rdata;

    logic [BYTES_W-1:0]  in_bytes;
    logic [ADDR_W-1:0]   in_addr, hoff;
    logic [ALLOC_W-1:0]  a_round;
    logic                f_bad;
    logic                fit;
    logic [31:0]         idx32;

    ffha_ram #(.WIDTH($bits(t_row)), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wrow),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign q = t_row'(rdata);

    assign in_bytes = i_s_tdata[BYTES_W-1:0];
    assign in_addr  = i_s_tdata[BYTES_W+ADDR_W-1:BYTES_W];
    assign a_round  = (ALLOC_W'(in_bytes) + ALLOC_W'(ALIGN_BYTES - 1))
                      & ~ALLOC_W'(ALIGN_BYTES - 1);
    assign hoff     = in_addr - ADDR_W'(HDR);
    assign idx32    = 32'(hoff >> ALOG);
    assign f_bad    = (in_addr < ADDR_W'(HDR)) || ((hoff & ADDR_W'(ALIGN_BYTES - 1)) != '0)
                      || (idx32 >= 32'(DEPTH));
    assign fit      = q.free && (CW'(q.size) >= r_need);

    always_comb begin
        n_state     = r_state;
        n_b         = r_b;
        n_s         = r_s;
        n_cur       = r_cur;
        n_succ      = r_succ;
        n_a         = r_a;
        n_need      = r_need;
        n_res_addr  = r_res_addr;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_addr  = r_out_addr;
        n_out_st    = r_out_st;
        we          = 1'b0;
        waddr       = r_b;
        wrow        = '0;
        raddr       = r_b;

        case (r_state)
            S_CLR: begin
                we = 1'b1;
                if (r_b == '0) begin
                    wrow = '{valid: 1'b1, free: 1'b1, size: INIT_SZ, nxt: NIL, prv: NIL};
                end
                if (r_b == LAST) begin
                    n_b     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_b = r_b + IW'(1);
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_res_addr = '0;
                    if (i_s_tuser[0] == OP_ALLOC) begin
                        if (in_bytes == '0) begin
                            n_res_st = ST_ZERO;
                            n_state  = S_DONE;
                        end else begin
                            n_a     = a_round;
                            n_need  = CW'(a_round) + CW'(HDR);
                            n_b     = '0;
                            raddr   = '0;
                            n_state = S_A_CHK;
                        end
                    end else begin
                        n_res_st = ST_FREED;
                        if (f_bad) begin
                            n_state = S_DONE;
                        end else begin
                            n_b     = IW'(idx32);
                            raddr   = IW'(idx32);
                            n_state = S_F_CHK;
                        end
                    end
                end
            end
            S_A_CHK: begin
                if (fit) begin
                    n_s   = r_b + IW'(r_need >> ALOG);
                    we    = 1'b1;
                    waddr = r_b + IW'(r_need >> ALOG);
                    wrow  = '{valid: 1'b1, free: 1'b1,
                              size: SZW'(CW'(q.size) - r_need),
                              nxt: q.nxt, prv: {1'b0, r_b}};
                    n_cur      = q;
                    n_res_addr = ADDR_W'((32'(r_b) << ALOG) + 32'(HDR));
                    n_res_st   = ST_ALLOC;
                    if (q.nxt != NIL) begin
                        raddr   = q.nxt[IW-1:0];
                        n_state = S_A_FIX;
                    end else begin
                        n_state = S_A_WRB;
                    end
                end else if (q.nxt == NIL) begin
                    n_res_st = ST_NOFIT;
                    n_state  = S_DONE;
                end else begin
                    n_b   = q.nxt[IW-1:0];
                    raddr = q.nxt[IW-1:0];
                end
            end
            S_A_FIX: begin
                // relink the old successor behind the new free remainder
                we       = 1'b1;
                waddr    = r_cur.nxt[IW-1:0];
                wrow     = q;
                wrow.prv = {1'b0, r_s};
                n_state  = S_A_WRB;
            end
            S_A_WRB: begin
                we      = 1'b1;
                waddr   = r_b;
                wrow    = '{valid: 1'b1, free: 1'b0, size: SZW'(r_a),
                            nxt: {1'b0, r_s}, prv: r_cur.prv};
                n_state = S_DONE;
            end
            S_F_CHK: begin
                if (!q.valid) begin
                    n_state = S_DONE;
                end else begin
                    n_cur      = q;
                    n_cur.free = 1'b1;
                    if (q.nxt == NIL) begin
                        n_state = S_F_BST;
                    end else begin
                        raddr   = q.nxt[IW-1:0];
                        n_state = S_F_FWD;
                    end
                end
            end
            S_F_FWD: begin
                if (q.free) begin
                    // absorb the free successor and drop its header
                    we        = 1'b1;
                    waddr     = r_cur.nxt[IW-1:0];
                    n_cur.size = r_cur.size + HDR_SZ + q.size;
                    n_cur.nxt = q.nxt;
                    if (q.nxt != NIL) begin
                        raddr = q.nxt[IW-1:0];
                    end else begin
                        n_state = S_F_BST;
                    end
                end else begin
                    n_succ  = q;
                    n_state = S_F_BST;
                end
            end
            S_F_BST: begin
                if (r_cur.prv == NIL) begin
                    n_state = S_F_FIN;
                end else begin
                    raddr   = r_cur.prv[IW-1:0];
                    n_state = S_F_BWD;
                end
            end
            S_F_BWD: begin
                if (q.free) begin
                    // fold the current block into its free predecessor
                    we         = 1'b1;
                    waddr      = r_b;
                    n_cur      = q;
                    n_cur.size = q.size + HDR_SZ + r_cur.size;
                    n_cur.nxt  = r_cur.nxt;
                    n_b        = r_cur.prv[IW-1:0];
                    if (q.prv != NIL) begin
                        raddr = q.prv[IW-1:0];
                    end else begin
                        n_state = S_F_FIN;
                    end
                end else begin
                    n_state = S_F_FIN;
                end
            end
            S_F_FIN: begin
                we    = 1'b1;
                waddr = r_b;
                wrow  = r_cur;
                if (r_cur.nxt != NIL) begin
                    n_state = S_F_FIX;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_F_FIX: begin
                we       = 1'b1;
                waddr    = r_cur.nxt[IW-1:0];
                wrow     = r_succ;
                wrow.prv = {1'b0, r_b};
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_addr  = r_res_addr;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_b         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_b         <= n_b;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s        <= n_s;
        r_cur      <= n_cur;
        r_succ     <= n_succ;
        r_a        <= n_a;
        r_need     <= n_need;
        r_res_addr <= n_res_addr;
        r_res_st   <= n_res_st;
        r_out_addr <= n_out_addr;
        r_out_st   <= n_out_st;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_DATA_W'(r_out_addr);
    assign o_m_tuser  = r_out_st;
endmodule

/* rtl/ffha_ram.sv */
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/ffha_chk.sv */
// Port-level checker for the first-fit heap allocator, bound to the top level
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_core_defines.svh"
module ffha_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [ffha_pkg::M_DATA_W-1:0] o_m_tdata,
    input logic [ffha_pkg::STAT_W-1:0]   o_m_tuser
);
    import ffha_pkg::*;

    `FFHA_ASSERT_NXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid, "result dropped while stalled")
    `FFHA_ASSERT_IMP(a_zero_addr, o_m_tvalid && (o_m_tuser != ST_ALLOC), o_m_tdata == '0, "nonzero address without grant")
    `FFHA_ASSERT_IMP(a_grant_align, o_m_tvalid && (o_m_tuser == ST_ALLOC), o_m_tdata[1:0] == 2'b00, "granted address misaligned")
    `FFHA_ASSERT_NXT(a_busy_after_take, i_s_tvalid && o_s_tready, !o_s_tready, "request taken while busy")
endmodule

bind first_fit_heap_allocator_core ffha_chk u_ffha_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

/* verif/testbench.sv */
// Testbench for the first-fit heap allocator: random request streams checked against a heap predictor
`timescale 1ns / 1ps
module testbench;
    import ffha_pkg::*;

    localparam int HEAP  = HEAP_BYTES_DEF;
    localparam int ALIGN = ALIGN_BYTES_DEF;
    localparam int HDR   = ((HEADER_BYTES_DEF + ALIGN - 1) / ALIGN) * ALIGN;
    localparam int DEPTH = HEAP / ALIGN;
    localparam logic [9:0] NIL = 10'h3FF;

    typedef struct packed {
        logic [M_DATA_W-1:0] payload;
        logic [STAT_W-1:0]   status;
    } t_grant;

    class heap_scoreboard;
        logic [12:0] size_of [DEPTH];
        bit          is_free [DEPTH];
        bit          in_chain [DEPTH];
        logic [9:0]  next_of [DEPTH];
        logic [9:0]  prev_of [DEPTH];
        t_grant      pending[$];
        logic [11:0] live[$];
        int          errors;

        function void clear_heap();
            for (int i = 0; i < DEPTH; i++) begin
                size_of[i] = '0;
                is_free[i] = 0;
                in_chain[i] = 0;
                next_of[i] = NIL;
                prev_of[i] = NIL;
            end
            size_of[0] = 13'(HEAP - HDR);
            is_free[0] = 1;
            in_chain[0] = 1;
            errors = 0;
        endfunction

        function void absorb(int left, int right);
            logic [9:0] after;
            after = next_of[right];
            size_of[left] = 13'(int'(size_of[left]) + HDR + int'(size_of[right]));
            next_of[left] = after;
            if (after != NIL) prev_of[after] = 10'(left);
            in_chain[right] = 0;
            next_of[right] = NIL;
            prev_of[right] = NIL;
            is_free[right] = 0;
        endfunction

        function void note_request(logic op, logic [12:0] nbytes, logic [11:0] addr);
            t_grant g;
            int a, need, b, steps, off, s, idx, hoff, p;
            logic [9:0] after;
            g.payload = '0;
            if (op == OP_ALLOC) begin
                g.status = ST_NOFIT;
                if (nbytes == 0) begin
                    g.status = ST_ZERO;
                end else begin
                    a = ((int'(nbytes) + ALIGN - 1) / ALIGN) * ALIGN;
                    need = a + HDR;
                    b = 0;
                    steps = 0;
                    while (b != int'(NIL) && b < DEPTH && steps <= DEPTH) begin
                        if (is_free[b] && int'(size_of[b]) >= need) begin
                            off = b * ALIGN;
                            s = (off + HDR + a) / ALIGN;
                            after = next_of[b];
                            size_of[s] = 13'(int'(size_of[b]) - need);
                            prev_of[s] = 10'(b);
                            next_of[s] = after;
                            if (after != NIL) prev_of[after] = 10'(s);
                            is_free[s] = 1;
                            in_chain[s] = 1;
                            size_of[b] = 13'(a);
                            next_of[b] = 10'(s);
                            is_free[b] = 0;
                            g.payload = M_DATA_W'((off + HDR) & 'hFFF);
                            g.status = ST_ALLOC;
                            live.push_back(g.payload[11:0]);
                            break;
                        end
                        b = int'(next_of[b]);
                        steps++;
                    end
                end
            end else begin
                g.status = ST_FREED;
                hoff = int'(addr) - HDR;
                idx = hoff / ALIGN;
                if (addr >= HDR && hoff % ALIGN == 0 && idx < DEPTH && in_chain[idx]) begin
                    is_free[idx] = 1;
                    foreach (live[i]) if (live[i] == addr) begin
                        live.delete(i);
                        break;
                    end
                    while (next_of[idx] != NIL && is_free[next_of[idx]])
                        absorb(idx, int'(next_of[idx]));
                    p = int'(prev_of[idx]);
                    while (p != int'(NIL) && is_free[p]) begin
                        absorb(p, idx);
                        idx = p;
                        p = int'(prev_of[idx]);
                    end
                end
            end
            pending.push_back(g);
        endfunction

        function void check_grant(logic [M_DATA_W-1:0] data, logic [STAT_W-1:0] stat);
            t_grant g;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: data %h status %0d", data, stat);
                return;
            end
            g = pending.pop_front();
            if (g.payload !== data || g.status !== stat) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected data %h status %0d, got data %h status %0d",
                             g.payload, g.status, data, stat);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_s_tvalid = 0;
    logic [S_DATA_W-1:0] i_s_tdata = '0;
    logic [0:0] i_s_tuser = '0;
    logic i_m_tready = 0;
    logic o_s_tready, o_m_tvalid;
    logic [M_DATA_W-1:0] o_m_tdata;
    logic [STAT_W-1:0] o_m_tuser;

    heap_scoreboard sb;
    int stall_left = 0;

    first_fit_heap_allocator_core dut (.*);

    always #6 i_clk = ~i_clk;

    initial begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    // Take results with random stalls between them
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                sb.check_grant(o_m_tdata, o_m_tuser);
                stall_left = int'($urandom_range(0, 8));
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_m_tready <= (stall_left == 0);
        end
    end

    task automatic send_request(logic op, logic [12:0] nbytes, logic [11:0] addr);
        int gap;
        gap = int'($urandom_range(0, 8));
        if (gap > 0) begin
            i_s_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser <= op;
        i_s_tdata <= {7'd0, addr, nbytes};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(op, nbytes, addr);
    endtask

    task automatic drain_results();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic free_some_live();
        if (sb.live.size() > 0)
            send_request(OP_FREE, 13'($urandom),
                         sb.live[$urandom_range(0, sb.live.size() - 1)]);
        else
            send_request(OP_FREE, 13'($urandom), 12'($urandom));
    endtask

    initial begin
        int pick;
        logic [11:0] a0;
        sb = new();
        sb.clear_heap();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed corners
        send_request(OP_ALLOC, 13'd0, 12'hFFF);
        send_request(OP_ALLOC, 13'd4096, 12'd0);
        send_request(OP_ALLOC, 13'h1FFF, 12'd0);
        send_request(OP_ALLOC, 13'd4032, 12'd0);      // exact fit, empty remainder
        send_request(OP_ALLOC, 13'd1, 12'd0);         // heap full
        send_request(OP_FREE, 13'h1FFF, 12'd32);
        send_request(OP_FREE, 13'd0, 12'd32);         // already free
        send_request(OP_ALLOC, 13'd1, 12'd0);
        a0 = sb.live[$];
        send_request(OP_ALLOC, 13'd9, 12'd0);
        send_request(OP_ALLOC, 13'd100, 12'd0);
        send_request(OP_FREE, 13'd0, 12'd0);          // below header
        send_request(OP_FREE, 13'd0, 12'd33);         // misaligned
        send_request(OP_FREE, 13'd0, 12'hFFF);        // misaligned, at the last byte of the heap
        send_request(OP_FREE, 13'd0, 12'd48);         // inside a block
        send_request(OP_FREE, 13'd0, 12'd72);         // middle block, merge later
        send_request(OP_FREE, 13'd0, a0);
        send_request(OP_FREE, 13'd0, sb.live[0]);
        send_request(OP_ALLOC, 13'd4064, 12'd0);

        for (int n = 0; n < 1000; n++) begin
            if (n == 500) begin
                i_s_tvalid <= 0;
                drain_results();
                @(posedge i_clk);
            end
            pick = int'($urandom_range(0, 99));
            if (pick < 50)
                send_request(OP_ALLOC, 13'($urandom_range(1, 160)), 12'($urandom));
            else if (pick < 55)
                send_request(OP_ALLOC, 13'($urandom_range(161, 4096)), 12'($urandom));
            else if (pick < 57)
                send_request(OP_ALLOC, 13'd0, 12'($urandom));
            else if (pick < 59)
                send_request(OP_ALLOC, 13'($urandom), 12'($urandom));
            else if (pick < 92)
                free_some_live();
            else
                send_request(OP_FREE, 13'($urandom), 12'($urandom));
        end
        i_s_tvalid <= 0;

        drain_results();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
